/* hdl/overwrite_log_ring_multi_reader_core_macros.svh */
// ----------------------------------------------------------------------------
// Overwrite log ring assertion macros
// Shared concurrent assertion forms for the log ring checkers.
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_LOG_RING_MULTI_READER_CORE_MACROS_SVH
`define OVERWRITE_LOG_RING_MULTI_READER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define OLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define OLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/olr_pkg.sv */
// ----------------------------------------------------------------------------
// olr_pkg
// Types and constants shared by the log ring controller and datapath.
// ----------------------------------------------------------------------------
package olr_pkg;

	localparam int OP_W     = 3;
	localparam int BYTE_W   = 8;
	localparam int RDR_W    = 2;
	localparam int THR_W    = 13;
	localparam int STORED_W = 2;
	localparam int MAX_LANES = 4;
	localparam int CNT_W    = 32;

	localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
	localparam logic [OP_W-1:0] OP_OPEN   = 3'd3;
	localparam logic [OP_W-1:0] OP_THRESH = 3'd4;
	localparam logic [OP_W-1:0] OP_FLUSH  = 3'd5;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

	typedef struct packed {
		logic capture;
		logic wr_first;
		logic wr_second;
		logic rd;
		logic open;
		logic thresh;
		logic flush;
		logic load_out;
	} olr_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            cr_drop;
		logic            lf_pair;
	} olr_sts_t;

endpackage

/* hdl/olr_ram.sv */
// ----------------------------------------------------------------------------
// olr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module olr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/olr_ctrl.sv */
// ----------------------------------------------------------------------------
// olr_ctrl
// Sequencer for the log ring: accepts a word, steps the datapath through the
// operation and hands the result to the output register.
// ----------------------------------------------------------------------------
module olr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  olr_pkg::olr_sts_t sts,
	output olr_pkg::olr_cmd_t cmd
);

	import olr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_WR2  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_FIN) && out_free);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
				case (sts.op)
					OP_WRITE: begin
						if (!sts.cr_drop) begin
							cmd.wr_first = 1'b1;
							if (sts.lf_pair) begin
								state_d = S_WR2;
							end
						end
					end
					OP_READ:   cmd.rd     = 1'b1;
					OP_OPEN:   cmd.open   = 1'b1;
					OP_THRESH: cmd.thresh = 1'b1;
					OP_FLUSH:  cmd.flush  = 1'b1;
					default: ;
				endcase
			end
			S_WR2: begin
				cmd.wr_second = 1'b1;
				state_d       = S_FIN;
			end
			S_FIN: begin
				// hold here until the output register frees up
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = accept ? S_EXEC : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/olr_dpath.sv */
// ----------------------------------------------------------------------------
// olr_dpath
// Log ring datapath: write count, reader counts and thresholds, byte store,
// fill level and readable mask, and the result register.
// ----------------------------------------------------------------------------
module olr_dpath #(
	parameter int BUF_DEPTH         = 4096,
	parameter int NUM_READERS       = 4,
	parameter int DEFAULT_THRESHOLD = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  olr_pkg::olr_cmd_t             cmd,
	output olr_pkg::olr_sts_t             sts,
	input  logic                          cfg_valid,
	input  logic                          cfg_data,
	input  logic [olr_pkg::OP_W-1:0]      operation,
	input  logic [olr_pkg::BYTE_W-1:0]    data_byte,
	input  logic [olr_pkg::RDR_W-1:0]     reader,
	input  logic [olr_pkg::THR_W-1:0]     threshold_value,
	output logic [olr_pkg::BYTE_W-1:0]    read_byte,
	output logic                          read_valid,
	output logic [olr_pkg::THR_W-1:0]     used_count,
	output logic [olr_pkg::MAX_LANES-1:0] readable_mask,
	output logic [olr_pkg::STORED_W-1:0]  bytes_stored
);

	import olr_pkg::*;

	localparam int NR = (NUM_READERS < MAX_LANES) ? NUM_READERS : MAX_LANES;
	localparam int RW = (NR > 1) ? $clog2(NR) : 1;
	localparam int AW = $clog2(BUF_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);
	localparam logic [THR_W-1:0] DEF_THR = THR_W'(DEFAULT_THRESHOLD);
	localparam logic [RDR_W:0]   NR_LIM  = (RDR_W + 1)'(NR);

	function automatic logic [CNT_W-1:0] used_sat(input logic [CNT_W-1:0] wc,
			input logic [CNT_W-1:0] rc);
		logic [CNT_W-1:0] diff;
		diff = wc - rc;
		return (diff > DEPTH_C) ? DEPTH_C : diff;
	endfunction

	// item registers
	logic [OP_W-1:0]   op_q;
	logic [BYTE_W-1:0] data_q;
	logic [RDR_W-1:0]  reader_q;
	logic [THR_W-1:0]  thr_val_q;

	logic              crlf_q;
	logic [CNT_W-1:0]  wc_q;
	logic [CNT_W-1:0]  rc_q  [NR];
	logic [THR_W-1:0]  thr_q [NR];
	logic              rvalid_q;
	logic [STORED_W-1:0] stored_q;

	logic [BYTE_W-1:0]   read_byte_q;
	logic                read_valid_q;
	logic [THR_W-1:0]    used_count_q;
	logic [MAX_LANES-1:0] mask_q;
	logic [STORED_W-1:0] bytes_stored_q;

	logic              ok;
	logic [RW-1:0]     ri;
	logic [CNT_W-1:0]  rc_sel;
	logic [CNT_W-1:0]  rd_diff;
	logic              rd_go;
	logic              overrun;
	logic [AW-1:0]     rd_addr;
	logic [CNT_W-1:0]  rc_after_rd;
	logic [CNT_W-1:0]  rc_open;
	logic [CNT_W-1:0]  used_sel;
	logic [MAX_LANES-1:0] mask_d;

	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_addr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [BYTE_W-1:0] ram_rdata;

	assign sts.op      = op_q;
	assign sts.cr_drop = crlf_q && (data_q == CHAR_CR);
	assign sts.lf_pair = crlf_q && (data_q == CHAR_LF);

	assign ok     = {1'b0, reader_q} < NR_LIM;
	assign ri     = reader_q[RW-1:0];
	assign rc_sel = rc_q[ri];

	// an overrun reader restarts at write_count - depth, which has the
	// same low address bits as the write count
	assign rd_diff     = wc_q - rc_sel;
	assign rd_go       = ok && (rd_diff != '0);
	assign overrun     = rd_diff > DEPTH_C;
	assign rd_addr     = overrun ? wc_q[AW-1:0] : rc_sel[AW-1:0];
	assign rc_after_rd = overrun ? (wc_q - DEPTH_C + CNT_W'(1)) : (rc_sel + CNT_W'(1));
	assign rc_open     = (wc_q > DEPTH_C) ? (wc_q - DEPTH_C) : '0;

	assign ram_we    = cmd.wr_first || cmd.wr_second;
	assign ram_re    = cmd.rd && rd_go;
	assign ram_addr  = cmd.rd ? rd_addr : wc_q[AW-1:0];
	assign ram_wdata = cmd.wr_second ? CHAR_LF : (sts.lf_pair ? CHAR_CR : data_q);

	olr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign used_sel = ok ? used_sat(wc_q, rc_sel) : '0;

	for (genvar i = 0; i < MAX_LANES; i++) begin : g_mask
		if (i < NR) begin : g_lane
			assign mask_d[i] = used_sat(wc_q, rc_q[i]) >= CNT_W'(thr_q[i]);
		end else begin : g_none
			assign mask_d[i] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			data_q    <= data_byte;
			reader_q  <= reader;
			thr_val_q <= threshold_value;
		end
		if (cmd.load_out) begin
			read_byte_q    <= rvalid_q ? ram_rdata : '0;
			read_valid_q   <= rvalid_q;
			used_count_q   <= used_sel[THR_W-1:0];
			mask_q         <= mask_d;
			bytes_stored_q <= stored_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crlf_q   <= 1'b0;
			wc_q     <= '0;
			rvalid_q <= 1'b0;
			stored_q <= '0;
			for (int i = 0; i < NR; i++) begin
				rc_q[i]  <= '0;
				thr_q[i] <= DEF_THR;
			end
		end else begin
			if (cfg_valid) begin
				crlf_q <= cfg_data;
			end
			if (cmd.capture) begin
				rvalid_q <= 1'b0;
				stored_q <= '0;
			end
			if (cmd.wr_first) begin
				stored_q <= sts.lf_pair ? STORED_W'(2) : STORED_W'(1);
			end
			if (ram_we) begin
				wc_q <= wc_q + CNT_W'(1);
			end
			if (ram_re) begin
				rvalid_q <= 1'b1;
			end
			if (cmd.flush) begin
				wc_q <= '0;
			end
			for (int i = 0; i < NR; i++) begin
				if (cmd.flush) begin
					rc_q[i] <= '0;
				end else if (ok && (ri == RW'(i))) begin
					if (ram_re) begin
						rc_q[i] <= rc_after_rd;
					end
					if (cmd.open) begin
						rc_q[i]  <= rc_open;
						thr_q[i] <= DEF_THR;
					end
					if (cmd.thresh) begin
						thr_q[i] <= thr_val_q;
					end
				end
			end
		end
	end

	assign read_byte     = read_byte_q;
	assign read_valid    = read_valid_q;
	assign used_count    = used_count_q;
	assign readable_mask = mask_q;
	assign bytes_stored  = bytes_stored_q;

endmodule

/* hdl/overwrite_log_ring_multi_reader_core.sv */
// ----------------------------------------------------------------------------
// overwrite_log_ring_multi_reader_core
// Overwriting byte log ring with several readers, each with its own count.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one operation word: write
//   a byte, read a byte, query the fill level, open a reader, set a reader's
//   notify threshold, or flush. Every word produces exactly one result word
//   on the output channel (out_valid/out_ready) in the same order.
//   The config channel (cfg_valid/cfg_ready, always ready) sets crlf_enable;
//   write it only while no word is in flight.
//   Timing: an accepted word steps through the EXEC and FIN states to its
//   result register, with a WR2 state between them for a line feed stored
//   as a CR LF pair, since the byte store has a single port and takes one
//   byte per cycle. The next word can be accepted in FIN as a result loads.
//   A finished result waits in the output register; the next word is still
//   accepted and worked on, and the block holds its result stage until the
//   receiver takes the waiting word.
//   Reset clears the write count and all reader counts, loads the default
//   thresholds and clears crlf_enable. The byte store is not cleared; no
//   legal sequence reads an entry that was never written.
// ----------------------------------------------------------------------------
module overwrite_log_ring_multi_reader_core #(
	parameter int BUF_DEPTH         = 4096,
	parameter int NUM_READERS       = 4,
	parameter int DEFAULT_THRESHOLD = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [olr_pkg::OP_W-1:0]      operation,
	input  logic [olr_pkg::BYTE_W-1:0]    data_byte,
	input  logic [olr_pkg::RDR_W-1:0]     reader,
	input  logic [olr_pkg::THR_W-1:0]     threshold_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [olr_pkg::BYTE_W-1:0]    read_byte,
	output logic                          read_valid,
	output logic [olr_pkg::THR_W-1:0]     used_count,
	output logic [olr_pkg::MAX_LANES-1:0] readable_mask,
	output logic [olr_pkg::STORED_W-1:0]  bytes_stored,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);

	import olr_pkg::*;

	olr_cmd_t cmd;
	olr_sts_t sts;

	assign cfg_ready = 1'b1;

	olr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	olr_dpath #(
		.BUF_DEPTH         (BUF_DEPTH),
		.NUM_READERS       (NUM_READERS),
		.DEFAULT_THRESHOLD (DEFAULT_THRESHOLD)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.data_byte       (data_byte),
		.reader          (reader),
		.threshold_value (threshold_value),
		.read_byte       (read_byte),
		.read_valid      (read_valid),
		.used_count      (used_count),
		.readable_mask   (readable_mask),
		.bytes_stored    (bytes_stored)
	);

endmodule

/* hdl/olr_chk.sv */
// ----------------------------------------------------------------------------
// olr_chk
// Port-level checks for the log ring, bound to the top level.
// ----------------------------------------------------------------------------
`include "overwrite_log_ring_multi_reader_core_macros.svh"

module olr_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [olr_pkg::BYTE_W-1:0]    read_byte,
	input logic                          read_valid,
	input logic [olr_pkg::THR_W-1:0]     used_count,
	input logic [olr_pkg::MAX_LANES-1:0] readable_mask,
	input logic [olr_pkg::STORED_W-1:0]  bytes_stored
);

	// a word that returned a byte stored nothing
	`OLR_ASSERT_NOW(a_read_no_store, clk, arst_n, out_valid && read_valid,
		bytes_stored == '0, "read word reports stored bytes")

	// an empty read returns a zero byte
	`OLR_ASSERT_NOW(a_empty_zero, clk, arst_n, out_valid && !read_valid,
		read_byte == '0, "empty read carries nonzero byte")

	// at most a CR LF pair per word
	`OLR_ASSERT_NOW(a_stored_max, clk, arst_n, out_valid,
		bytes_stored != 2'd3, "bytes stored out of range")

	// hold a stalled result
	`OLR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(read_byte) && $stable(used_count) && $stable(readable_mask),
		"stalled result changed")

endmodule

bind overwrite_log_ring_multi_reader_core olr_chk u_olr_chk (.*);
